FILE: design/ndsim_pkg.sv
// Shared types and constants for the tensor slice address generator.
package ndsim_pkg;

  localparam int FIELD_W   = 32;
  localparam int CFG_W     = 64;
  localparam int CNT_W     = 3;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_DIM_COUNT = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_OUT_SHAPE = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_IN_SHAPE  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BEGIN     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_TOTAL     = 3'd4;

  localparam int DEF_MAX_DIMS   = 4;
  localparam int DEF_DIM_BITS   = 16;
  localparam int DEF_INDEX_BITS = 32;

  localparam logic [CFG_W-1:0] SHAPE_RESET = 64'h0001_0001_0001_0001;

  // Control bits that travel alongside each item through the cell chain.
  typedef struct packed {
    logic valid;
    logic last;
  } ndsim_ctl_t;

endpackage

FILE: design/ndsim_div_cell.sv
// One restoring-division cell: produces one quotient bit per item and passes the item on.
module ndsim_div_cell #(
  parameter int DIM_BITS   = ndsim_pkg::DEF_DIM_BITS,
  parameter int INDEX_BITS = ndsim_pkg::DEF_INDEX_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic [DIM_BITS-1:0]         divisor,
  input  ndsim_pkg::ndsim_ctl_t       ctl_in,
  input  logic [ndsim_pkg::FIELD_W-1:0] idx_in,
  input  logic [INDEX_BITS-1:0]       orig_in,
  input  logic [DIM_BITS-1:0]         rem_in,
  input  logic [INDEX_BITS-1:0]       quo_in,
  input  logic [INDEX_BITS-1:0]       src_in,
  input  logic [INDEX_BITS-1:0]       wt_in,
  output ndsim_pkg::ndsim_ctl_t       ctl_out,
  output logic [ndsim_pkg::FIELD_W-1:0] idx_out,
  output logic [INDEX_BITS-1:0]       orig_out,
  output logic [DIM_BITS-1:0]         rem_out,
  output logic [INDEX_BITS-1:0]       quo_out,
  output logic [INDEX_BITS-1:0]       src_out,
  output logic [INDEX_BITS-1:0]       wt_out
);
  import ndsim_pkg::*;

  ndsim_ctl_t            ctl_r;
  logic [FIELD_W-1:0]    idx_r;
  logic [INDEX_BITS-1:0] orig_r, quo_r, src_r, wt_r;
  logic [DIM_BITS-1:0]   rem_r;
  logic [DIM_BITS:0]     trial, diff;
  logic                  qbit;
  logic [DIM_BITS-1:0]   rem_nxt;
  logic [INDEX_BITS-1:0] quo_nxt;

  always_comb begin
    trial   = {rem_in, quo_in[INDEX_BITS-1]};
    diff    = trial - {1'b0, divisor};
    qbit    = (trial >= {1'b0, divisor});
    rem_nxt = qbit ? diff[DIM_BITS-1:0] : trial[DIM_BITS-1:0];
    quo_nxt = {quo_in[INDEX_BITS-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= ctl_in;
    end
    if (adv) begin
      idx_r  <= idx_in;
      orig_r <= orig_in;
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
      src_r  <= src_in;
      wt_r   <= wt_in;
    end
  end

  assign ctl_out  = ctl_r;
  assign idx_out  = idx_r;
  assign orig_out = orig_r;
  assign rem_out  = rem_r;
  assign quo_out  = quo_r;
  assign src_out  = src_r;
  assign wt_out   = wt_r;

endmodule

FILE: design/ndsim_mac_cell.sv
// Two-stage cell that offsets a coordinate and folds it into the source index.
module ndsim_mac_cell #(
  parameter int DIM_BITS   = ndsim_pkg::DEF_DIM_BITS,
  parameter int INDEX_BITS = ndsim_pkg::DEF_INDEX_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        active,
  input  logic [DIM_BITS-1:0]         divisor,
  input  logic [DIM_BITS-1:0]         in_ext,
  input  logic [DIM_BITS-1:0]         beg,
  input  ndsim_pkg::ndsim_ctl_t       ctl_in,
  input  logic [ndsim_pkg::FIELD_W-1:0] idx_in,
  input  logic [INDEX_BITS-1:0]       orig_in,
  input  logic [DIM_BITS-1:0]         rem_in,
  input  logic [INDEX_BITS-1:0]       quo_in,
  input  logic [INDEX_BITS-1:0]       src_in,
  input  logic [INDEX_BITS-1:0]       wt_in,
  output ndsim_pkg::ndsim_ctl_t       ctl_out,
  output logic [ndsim_pkg::FIELD_W-1:0] idx_out,
  output logic [INDEX_BITS-1:0]       rest_out,
  output logic [INDEX_BITS-1:0]       src_out,
  output logic [INDEX_BITS-1:0]       wt_out
);
  import ndsim_pkg::*;

  ndsim_ctl_t              ctl1_r, ctl2_r;
  logic [FIELD_W-1:0]      idx1_r, idx2_r;
  logic [INDEX_BITS-1:0]   prod_r, wnew_r, quo1_r, orig1_r, src1_r, wt1_r;
  logic                    act1_r;
  logic [INDEX_BITS-1:0]   rem_full, coord, quo_sel;
  logic [2*INDEX_BITS-1:0] prod_full;
  logic [INDEX_BITS+DIM_BITS-1:0] wt_full;
  logic [INDEX_BITS-1:0]   rest_nxt, src_nxt, wt_nxt;

  always_comb begin
    // A zero extent leaves the whole running index as the coordinate.
    if (divisor == '0) begin
      rem_full = orig_in;
      quo_sel  = '0;
    end else begin
      rem_full = INDEX_BITS'(rem_in);
      quo_sel  = quo_in;
    end
    coord     = INDEX_BITS'(beg) + rem_full;
    prod_full = coord * wt_in;
    wt_full   = wt_in * in_ext;
  end

  always_comb begin
    rest_nxt = act1_r ? quo1_r : orig1_r;
    src_nxt  = act1_r ? src1_r + prod_r : src1_r;
    wt_nxt   = act1_r ? wnew_r : wt1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
    end else if (adv) begin
      ctl1_r <= ctl_in;
      ctl2_r <= ctl1_r;
    end
    if (adv) begin
      idx1_r  <= idx_in;
      act1_r  <= active;
      prod_r  <= prod_full[INDEX_BITS-1:0];
      wnew_r  <= wt_full[INDEX_BITS-1:0];
      quo1_r  <= quo_sel;
      orig1_r <= orig_in;
      src1_r  <= src_in;
      wt1_r   <= wt_in;
      idx2_r  <= idx1_r;
      rest_out <= rest_nxt;
      src_out  <= src_nxt;
      wt_out   <= wt_nxt;
    end
  end

  assign ctl_out = ctl2_r;
  assign idx_out = idx2_r;

endmodule

FILE: design/ndsim_dim.sv
// One dimension of the chain: a row of division cells followed by the offset cell.
module ndsim_dim #(
  parameter int DIM_BITS   = ndsim_pkg::DEF_DIM_BITS,
  parameter int INDEX_BITS = ndsim_pkg::DEF_INDEX_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        active,
  input  logic [DIM_BITS-1:0]         out_ext,
  input  logic [DIM_BITS-1:0]         in_ext,
  input  logic [DIM_BITS-1:0]         beg,
  input  ndsim_pkg::ndsim_ctl_t       ctl_in,
  input  logic [ndsim_pkg::FIELD_W-1:0] idx_in,
  input  logic [INDEX_BITS-1:0]       rest_in,
  input  logic [INDEX_BITS-1:0]       src_in,
  input  logic [INDEX_BITS-1:0]       wt_in,
  output ndsim_pkg::ndsim_ctl_t       ctl_out,
  output logic [ndsim_pkg::FIELD_W-1:0] idx_out,
  output logic [INDEX_BITS-1:0]       rest_out,
  output logic [INDEX_BITS-1:0]       src_out,
  output logic [INDEX_BITS-1:0]       wt_out
);
  import ndsim_pkg::*;

  ndsim_ctl_t            ctl_c  [0:INDEX_BITS];
  logic [FIELD_W-1:0]    idx_c  [0:INDEX_BITS];
  logic [INDEX_BITS-1:0] orig_c [0:INDEX_BITS];
  logic [DIM_BITS-1:0]   rem_c  [0:INDEX_BITS];
  logic [INDEX_BITS-1:0] quo_c  [0:INDEX_BITS];
  logic [INDEX_BITS-1:0] src_c  [0:INDEX_BITS];
  logic [INDEX_BITS-1:0] wt_c   [0:INDEX_BITS];

  assign ctl_c[0]  = ctl_in;
  assign idx_c[0]  = idx_in;
  assign orig_c[0] = rest_in;
  assign rem_c[0]  = '0;
  assign quo_c[0]  = rest_in;
  assign src_c[0]  = src_in;
  assign wt_c[0]   = wt_in;

  for (genvar i = 0; i < INDEX_BITS; i++) begin : g_cell
    ndsim_div_cell #(.DIM_BITS(DIM_BITS), .INDEX_BITS(INDEX_BITS)) u_cell (
      .clk(clk), .rst_n(rst_n), .adv(adv), .divisor(out_ext),
      .ctl_in(ctl_c[i]), .idx_in(idx_c[i]), .orig_in(orig_c[i]), .rem_in(rem_c[i]),
      .quo_in(quo_c[i]), .src_in(src_c[i]), .wt_in(wt_c[i]),
      .ctl_out(ctl_c[i+1]), .idx_out(idx_c[i+1]), .orig_out(orig_c[i+1]),
      .rem_out(rem_c[i+1]), .quo_out(quo_c[i+1]), .src_out(src_c[i+1]),
      .wt_out(wt_c[i+1])
    );
  end

  ndsim_mac_cell #(.DIM_BITS(DIM_BITS), .INDEX_BITS(INDEX_BITS)) u_mac (
    .clk(clk), .rst_n(rst_n), .adv(adv), .active(active), .divisor(out_ext),
    .in_ext(in_ext), .beg(beg),
    .ctl_in(ctl_c[INDEX_BITS]), .idx_in(idx_c[INDEX_BITS]), .orig_in(orig_c[INDEX_BITS]),
    .rem_in(rem_c[INDEX_BITS]), .quo_in(quo_c[INDEX_BITS]), .src_in(src_c[INDEX_BITS]),
    .wt_in(wt_c[INDEX_BITS]),
    .ctl_out(ctl_out), .idx_out(idx_out), .rest_out(rest_out), .src_out(src_out),
    .wt_out(wt_out)
  );

endmodule

FILE: design/nd_slice_index_map.sv
// Top level of the tensor slice address generator with configuration registers.
// Each item passes through every dimension's division cells and offset cell, then the output register.
// Throughput: one item per cycle while in_stall is low; each dimension is a chain of one-bit division cells.
// A two-entry output buffer lets the chain keep moving while one result is stalled.
// Synchronous reset empties the chain and loads the register reset values.
module nd_slice_index_map #(
  parameter int MAX_DIMS   = ndsim_pkg::DEF_MAX_DIMS,
  parameter int DIM_BITS   = ndsim_pkg::DEF_DIM_BITS,
  parameter int INDEX_BITS = ndsim_pkg::DEF_INDEX_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ndsim_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [ndsim_pkg::CFG_W-1:0]      cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [ndsim_pkg::FIELD_W-1:0]    in_out_index,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [ndsim_pkg::FIELD_W-1:0]    out_dest_index,
  output logic [ndsim_pkg::FIELD_W-1:0]    out_src_index,
  output logic                             out_last_element
);
  import ndsim_pkg::*;

  logic [CNT_W-1:0]   dim_count_r;
  logic [CFG_W-1:0]   out_shape_r, in_shape_r, begin_r;
  logic [FIELD_W-1:0] total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_count_r <= CNT_W'(1);
      out_shape_r <= SHAPE_RESET;
      in_shape_r  <= SHAPE_RESET;
      begin_r     <= '0;
      total_r     <= FIELD_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DIM_COUNT: dim_count_r <= cfg_data[CNT_W-1:0];
        REG_OUT_SHAPE: out_shape_r <= cfg_data;
        REG_IN_SHAPE:  in_shape_r  <= cfg_data;
        REG_BEGIN:     begin_r     <= cfg_data;
        REG_TOTAL:     total_r     <= cfg_data[FIELD_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  logic [CNT_W-1:0] dims_eff;
  assign dims_eff = (dim_count_r > CNT_W'(MAX_DIMS)) ? CNT_W'(MAX_DIMS) : dim_count_r;

  // Stage g handles lane dims_eff-1-g, innermost first.
  logic                  act_g  [0:MAX_DIMS-1];
  logic [DIM_BITS-1:0]   oext_g [0:MAX_DIMS-1];
  logic [DIM_BITS-1:0]   iext_g [0:MAX_DIMS-1];
  logic [DIM_BITS-1:0]   beg_g  [0:MAX_DIMS-1];

  for (genvar g = 0; g < MAX_DIMS; g++) begin : g_sel
    logic [CNT_W-1:0] lane;
    always_comb begin
      lane      = dims_eff - CNT_W'(g + 1);
      act_g[g]  = (CNT_W'(g) < dims_eff);
      oext_g[g] = '0;
      iext_g[g] = '0;
      beg_g[g]  = '0;
      for (int l = 0; l < MAX_DIMS; l++) begin
        if (lane == CNT_W'(l)) begin
          oext_g[g] = out_shape_r[l*DIM_BITS +: DIM_BITS];
          iext_g[g] = in_shape_r[l*DIM_BITS +: DIM_BITS];
          beg_g[g]  = begin_r[l*DIM_BITS +: DIM_BITS];
        end
      end
    end
  end

  logic skid_v_r;
  logic adv;
  assign adv      = !skid_v_r;
  assign in_stall = skid_v_r;

  ndsim_ctl_t            ctl_d  [0:MAX_DIMS];
  logic [FIELD_W-1:0]    idx_d  [0:MAX_DIMS];
  logic [INDEX_BITS-1:0] rest_d [0:MAX_DIMS];
  logic [INDEX_BITS-1:0] src_d  [0:MAX_DIMS];
  logic [INDEX_BITS-1:0] wt_d   [0:MAX_DIMS];
  logic [FIELD_W-1:0]    total_m1;

  assign total_m1       = total_r - FIELD_W'(1);
  assign ctl_d[0].valid = in_valid;
  assign ctl_d[0].last  = (total_r != '0) && (in_out_index == total_m1);
  assign idx_d[0]       = in_out_index;
  assign src_d[0]       = '0;
  assign wt_d[0]        = INDEX_BITS'(1);

  if (INDEX_BITS >= FIELD_W) begin : g_wide
    assign rest_d[0] = INDEX_BITS'(in_out_index);
  end else begin : g_narrow
    assign rest_d[0] = in_out_index[INDEX_BITS-1:0];
  end

  for (genvar g = 0; g < MAX_DIMS; g++) begin : g_dim
    ndsim_dim #(.DIM_BITS(DIM_BITS), .INDEX_BITS(INDEX_BITS)) u_dim (
      .clk(clk), .rst_n(rst_n), .adv(adv), .active(act_g[g]),
      .out_ext(oext_g[g]), .in_ext(iext_g[g]), .beg(beg_g[g]),
      .ctl_in(ctl_d[g]), .idx_in(idx_d[g]), .rest_in(rest_d[g]), .src_in(src_d[g]),
      .wt_in(wt_d[g]),
      .ctl_out(ctl_d[g+1]), .idx_out(idx_d[g+1]), .rest_out(rest_d[g+1]),
      .src_out(src_d[g+1]), .wt_out(wt_d[g+1])
    );
  end

  logic [FIELD_W-1:0] src_fin;
  if (INDEX_BITS >= FIELD_W) begin : g_out_wide
    assign src_fin = src_d[MAX_DIMS][FIELD_W-1:0];
  end else begin : g_out_narrow
    assign src_fin = FIELD_W'(src_d[MAX_DIMS]);
  end

  logic               out_v_r, out_last_r, skid_last_r;
  logic [FIELD_W-1:0] out_dest_r, out_src_r, skid_dest_r, skid_src_r;

  // The chain only moves while the skid entry is empty, so a stalled result never blocks
  // the transfer that is already on its way out of the last cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || !out_stall) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= ctl_d[MAX_DIMS].valid;
      end
    end else if (adv && ctl_d[MAX_DIMS].valid) begin
      skid_v_r <= 1'b1;
    end
    if (!out_v_r || !out_stall) begin
      if (skid_v_r) begin
        out_dest_r <= skid_dest_r;
        out_src_r  <= skid_src_r;
        out_last_r <= skid_last_r;
      end else begin
        out_dest_r <= idx_d[MAX_DIMS];
        out_src_r  <= src_fin;
        out_last_r <= ctl_d[MAX_DIMS].last;
      end
    end else if (adv) begin
      skid_dest_r <= idx_d[MAX_DIMS];
      skid_src_r  <= src_fin;
      skid_last_r <= ctl_d[MAX_DIMS].last;
    end
  end

  assign out_valid        = out_v_r;
  assign out_dest_index   = out_dest_r;
  assign out_src_index    = out_src_r;
  assign out_last_element = out_last_r;

endmodule

FILE: tb/tb_nd_slice_index_map.sv
// Self-checking testbench for the tensor slice address generator.
module tb_nd_slice_index_map;
  timeunit 1ns;
  timeprecision 1ps;
  import ndsim_pkg::*;

  localparam int LANES = DEF_MAX_DIMS;
  localparam int LANE_W = DEF_DIM_BITS;
  localparam int PIPE_LAT = DEF_MAX_DIMS * (DEF_INDEX_BITS + 2) + 1;
  localparam int WATCHDOG = 20000;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [FIELD_W-1:0] dest;
    logic [FIELD_W-1:0] src;
    logic               last;
  } addr_rec_t;

  typedef struct {
    logic [REG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
  } cfg_op_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [FIELD_W-1:0] in_out_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [FIELD_W-1:0] out_dest_index;
  logic [FIELD_W-1:0] out_src_index;
  logic out_last_element;

  nd_slice_index_map dut (.*);

  always #10ns clk = ~clk;

  // Shadow copy of the configuration registers.
  logic [2:0]         sh_dims = 3'd1;
  logic [CFG_W-1:0]   sh_oshape = SHAPE_RESET;
  logic [CFG_W-1:0]   sh_ishape = SHAPE_RESET;
  logic [CFG_W-1:0]   sh_begin = '0;
  logic [FIELD_W-1:0] sh_total = 32'd1;

  addr_rec_t pending_addrs[$];
  int errors = 0;
  int checked = 0;
  int sent = 0;
  int idle_cycles = 0;
  int src_idle_pct = 0;
  int dst_idle_pct = 0;
  int hold_off = 0;

  function automatic addr_rec_t map_slice_addr(logic [FIELD_W-1:0] idx);
    addr_rec_t r;
    logic [31:0] rest, src, weight, oext, iext, beg, rem, quo;
    int dims;
    dims = (sh_dims > LANES) ? LANES : sh_dims;
    rest = idx;
    src = 0;
    weight = 1;
    for (int k = dims - 1; k >= 0; k--) begin
      oext = 32'(sh_oshape[k*LANE_W +: LANE_W]);
      iext = 32'(sh_ishape[k*LANE_W +: LANE_W]);
      beg = 32'(sh_begin[k*LANE_W +: LANE_W]);
      if (oext == 0) begin
        rem = rest;
        quo = 0;
      end else begin
        rem = rest % oext;
        quo = rest / oext;
      end
      src = src + (beg + rem) * weight;
      weight = weight * iext;
      rest = quo;
    end
    r.dest = idx;
    r.src = src;
    r.last = (sh_total != 0) && (idx == sh_total - 1);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [FIELD_W-1:0] got,
                                 logic [FIELD_W-1:0] want);
    errors++;
    $display("MISMATCH %s: got %0h expected %0h (result %0d)", what, got, want, checked);
  endtask

  // Result checker and receiver-side stall generation.
  always @(posedge clk) begin
    addr_rec_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_addrs.size() == 0) begin
        report_mismatch("unexpected result dest", out_dest_index, '0);
      end else begin
        e = pending_addrs.pop_front();
        if (out_dest_index !== e.dest) report_mismatch("dest_index", out_dest_index, e.dest);
        if (out_src_index !== e.src) report_mismatch("src_index", out_src_index, e.src);
        if (out_last_element !== e.last)
          report_mismatch("last_element", 32'(out_last_element), 32'(e.last));
      end
      checked++;
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog expired with %0d results outstanding", pending_addrs.size());
      $display("nd_slice_index_map verification failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_stall <= 1'b1;
      hold_off <= hold_off - 1;
    end else begin
      out_stall <= ($urandom_range(99) < dst_idle_pct);
    end
  end

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_DIM_COUNT: sh_dims = data[2:0];
      REG_OUT_SHAPE: sh_oshape = data;
      REG_IN_SHAPE:  sh_ishape = data;
      REG_BEGIN:     sh_begin = data;
      REG_TOTAL:     sh_total = data[31:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Offers one item; valid stays high between back-to-back items.
  task automatic send_index(logic [FIELD_W-1:0] idx);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_out_index <= idx;
    do @(posedge clk); while (in_stall);
    pending_addrs.push_back(map_slice_addr(idx));
    sent++;
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_addrs.size() != 0) @(negedge clk);
    repeat (PIPE_LAT + 10) @(negedge clk);
  endtask

  // Random but consistent slice geometry; occasionally the odd corners.
  task automatic random_geometry;
    logic [CFG_W-1:0] os, is, bg;
    logic [31:0] tot;
    int d, mode;
    d = $urandom_range(LANES, 1);
    mode = $urandom_range(9);
    tot = 1;
    for (int k = 0; k < LANES; k++) begin
      logic [15:0] o, b, i;
      o = (mode == 0) ? 16'($urandom) : 16'($urandom_range(7, 1));
      b = (mode == 1) ? 16'($urandom) : 16'($urandom_range(5));
      i = (mode == 2) ? 16'($urandom) : o + b + 16'($urandom_range(3));
      os[k*16 +: 16] = o;
      bg[k*16 +: 16] = b;
      is[k*16 +: 16] = i;
      if (k < d) tot = tot * o;
    end
    write_reg(REG_DIM_COUNT, (mode == 3) ? CFG_W'($urandom_range(7)) : CFG_W'(d));
    write_reg(REG_OUT_SHAPE, os);
    write_reg(REG_IN_SHAPE, is);
    write_reg(REG_BEGIN, bg);
    write_reg(REG_TOTAL, (mode == 4) ? CFG_W'($urandom) : CFG_W'(tot));
  endtask

  cfg_op_t dir_cfg[] = '{
    '{REG_DIM_COUNT, 64'd4},
    '{REG_OUT_SHAPE, 64'h0003_0004_0005_0006},
    '{REG_IN_SHAPE, 64'hFFFF_FFFF_FFFF_FFFF},
    '{REG_BEGIN, 64'hFFFF_0000_FFFF_0001},
    '{REG_TOTAL, 64'hFFFF_FFFF_FFFF_FFFF}};

  // Directed rows: index, whether the expectation is typed in, and its fields.
  typedef struct {
    logic [31:0] idx;
    bit          typed;
    addr_rec_t   want;
  } dir_row_t;

  dir_row_t reset_rows[] = '{
    '{32'd0, 1'b1, '{32'd0, 32'd0, 1'b1}},
    '{32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 32'd0, 1'b0}},
    '{32'h5555_AAAA, 1'b1, '{32'h5555_AAAA, 32'd0, 1'b0}}};

  initial begin
    addr_rec_t got;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Register reset values: one dimension of extent one.
    foreach (reset_rows[i]) begin
      send_index(reset_rows[i].idx);
      if (reset_rows[i].typed) begin
        got = pending_addrs[pending_addrs.size() - 1];
        if (got != reset_rows[i].want) report_mismatch("reset row", got.src,
                                                        reset_rows[i].want.src);
      end
    end
    drain();

    // Extreme settings: full rank, all-ones extents and wrap, empty tensor,
    // zero rank, rank past the maximum, zero extent, unknown register index.
    foreach (dir_cfg[i]) write_reg(dir_cfg[i].idx, dir_cfg[i].data);
    foreach (reset_rows[i]) send_index(reset_rows[i].idx);
    send_index(32'hFFFF_FFFE);
    send_index(32'd119);
    drain();
    write_reg(REG_TOTAL, 64'd0);
    write_reg(REG_OUT_SHAPE, 64'h0000_0007_0000_FFFF);
    write_reg(REG_UNUSED_HI, 64'hDEAD_BEEF);
    write_reg(REG_UNUSED_LO, 64'h1);
    send_index(32'd0);
    send_index(32'hFFFF_FFFF);
    send_index(32'h0001_2345);
    drain();
    write_reg(REG_DIM_COUNT, 64'd0);
    send_index(32'h1234_5678);
    drain();
    write_reg(REG_DIM_COUNT, 64'd7);
    write_reg(REG_TOTAL, 64'h1_0000_0000);
    send_index(32'hFFFF_FFFF);
    send_index(32'h8000_0001);
    drain();

    // Random part in three idling phases.
    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = (ph == 0) ? 21 : (ph == 1) ? 58 : 0;
      dst_idle_pct = (ph == 0) ? 58 : (ph == 1) ? 21 : 0;
      for (int g = 0; g < 10; g++) begin
        int burst;
        random_geometry();
        // With no sender gaps, the longer burst fills the whole chain during the hold-off.
        burst = (ph == 2 && g == 3) ? 180 : 62;
        if (g == 3) hold_off = 400;  // long receiver hold-off while items keep coming
        for (int n = 0; n < burst; n++) begin
          logic [31:0] v;
          case ($urandom_range(9))
            0: v = $urandom;
            1: v = sh_total - 1;
            default: v = (sh_total > 2) ? $urandom_range(sh_total - 1) : $urandom_range(3);
          endcase
          send_index(v);
        end
        // The sender waits here for every expected result.
        drain();
      end
    end

    $display("Covered %0d items, %0d results checked over directed and random slices.",
             sent, checked);
    $display("Idling phases and a long receiver hold-off were exercised.");
    if (errors == 0)
      $display("nd_slice_index_map verification clean");
    else
      $display("nd_slice_index_map verification failed");
    $finish;
  end
endmodule
